### rtl/fat_volume_geometry_calc_unit_assert.svh
// Assertion macros shared by the checker of the FAT volume geometry unit.
// Depends on nothing; included by the checker file.
`ifndef FAT_VOLUME_GEOMETRY_CALC_UNIT_ASSERT_SVH
`define FAT_VOLUME_GEOMETRY_CALC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FVG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fvg_pkg.sv
// Package of the FAT volume geometry unit: widths, codes, FSM type, sideband struct.
// Depends on nothing; used by every module of the block.
package fvg_pkg;

    localparam int FVG_DIVD_W      = 32;
    localparam int FVG_BPS_W       = 13;
    localparam int FVG_SPC_W       = 8;
    localparam int FVG_CLUSTER_W   = 28;
    localparam int FVG_RDS_EXACT_W = 22;
    localparam int FVG_ROOT_W      = 24;
    localparam int FVG_DATA_W      = 25;
    localparam int FVG_OFF_W       = 12;
    localparam int FVG_IDX_W       = 3;
    localparam int FVG_DIV_BITS    = 4;
    localparam int FVG_ITER_CNT_W  = $clog2(FVG_DIVD_W + 1);

    localparam logic [31:0] FVG_FAT12_LIMIT = 32'd4085;
    localparam logic [31:0] FVG_FAT16_LIMIT = 32'd65525;
    localparam logic [12:0] FVG_RDS_SAT     = 13'd8191;
    localparam logic [12:0] FVG_OFF_SAT     = 13'd4095;

    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_LOW_CLUSTER = 2'd1;
    localparam logic [1:0] STATUS_FAT12_UNSUP = 2'd2;

    localparam logic [2:0] REG_BPS   = 3'd0;
    localparam logic [2:0] REG_SPC   = 3'd1;
    localparam logic [2:0] REG_RES   = 3'd2;
    localparam logic [2:0] REG_COPY  = 3'd3;
    localparam logic [2:0] REG_ROOTN = 3'd4;
    localparam logic [2:0] REG_TSIZE = 3'd5;
    localparam logic [2:0] REG_TOT16 = 3'd6;
    localparam logic [2:0] REG_TOT32 = 3'd7;

    typedef enum logic [2:0] {
        GEO_RDS_GO,
        GEO_RDS_WAIT,
        GEO_ROOT,
        GEO_DATA,
        GEO_CNT_GO,
        GEO_CNT_WAIT,
        GEO_READY
    } t_geo_state;

    // Per-item values that ride alongside the divider pipeline.
    typedef struct packed {
        logic        low_cluster;
        logic [31:0] start_sector;
    } t_side;

    // Handshake between the geometry sequencer and the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [12:0] divisor;
    } t_div_req;

endpackage

### rtl/fvg_div_iter.sv
// Iterative radix-2 divider, one quotient bit per cycle, for geometry setup.
// Depends on fvg_pkg.
module fvg_div_iter
    import fvg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_req              i_req,
    output logic                  o_done,
    output logic [FVG_DIVD_W-1:0] o_quotient
);

    logic [FVG_ITER_CNT_W-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [FVG_DIVD_W-1:0]     r_q;
    logic [FVG_BPS_W-1:0]      r_rem;
    logic [FVG_BPS_W-1:0]      r_div;
    logic [FVG_BPS_W:0]        w_t;
    logic                      w_ge;

    assign w_t  = {r_rem, r_q[FVG_DIVD_W-1]};
    assign w_ge = (w_t >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= FVG_ITER_CNT_W'(FVG_DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - FVG_ITER_CNT_W'(1);
                if (r_cnt == FVG_ITER_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[FVG_DIVD_W-2:0], w_ge};
            r_rem <= w_ge ? FVG_BPS_W'(w_t - {1'b0, r_div}) : w_t[FVG_BPS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

### rtl/fvg_div_pipe.sv
// Pipelined restoring divider, P_BITS quotient bits per stage, with sideband payload.
// Depends on fvg_pkg.
module fvg_div_pipe
    import fvg_pkg::*;
#(
    parameter int P_BITS = FVG_DIV_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic [FVG_DIVD_W-1:0] i_dividend,
    input  logic [FVG_BPS_W-1:0]  i_divisor,
    input  t_side                 i_side,
    output logic                  o_valid,
    output logic                  o_busy,
    output logic [FVG_DIVD_W-1:0] o_quotient,
    output logic [FVG_BPS_W-1:0]  o_remainder,
    output t_side                 o_side
);

    localparam int STAGES = FVG_DIVD_W / P_BITS;

    logic [STAGES-1:0]     r_vld;
    logic [FVG_DIVD_W-1:0] r_q   [STAGES];
    logic [FVG_BPS_W-1:0]  r_rem [STAGES];
    t_side                 r_side[STAGES];
    logic [FVG_DIVD_W-1:0] n_q   [STAGES];
    logic [FVG_BPS_W-1:0]  n_rem [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [FVG_DIVD_W-1:0] w_in_q;
        logic [FVG_BPS_W-1:0]  w_in_rem;
        logic                  w_in_vld;
        t_side                 w_in_side;

        if (s == 0) begin : g_first
            assign w_in_q    = i_dividend;
            assign w_in_rem  = '0;
            assign w_in_vld  = i_valid;
            assign w_in_side = i_side;
        end else begin : g_next
            assign w_in_q    = r_q[s-1];
            assign w_in_rem  = r_rem[s-1];
            assign w_in_vld  = r_vld[s-1];
            assign w_in_side = r_side[s-1];
        end

        always_comb begin
            logic [FVG_BPS_W:0]    t;
            logic [FVG_BPS_W-1:0]  rem;
            logic [FVG_DIVD_W-1:0] q;
            rem = w_in_rem;
            q   = w_in_q;
            for (int k = 0; k < P_BITS; k++) begin
                t = {rem, q[FVG_DIVD_W-1]};
                if (t >= {1'b0, i_divisor}) begin
                    rem = FVG_BPS_W'(t - {1'b0, i_divisor});
                    q   = {q[FVG_DIVD_W-2:0], 1'b1};
                end else begin
                    rem = t[FVG_BPS_W-1:0];
                    q   = {q[FVG_DIVD_W-2:0], 1'b0};
                end
            end
            n_rem[s] = rem;
            n_q[s]   = q;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_adv) begin
                r_vld[s] <= w_in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv && w_in_vld) begin
                r_q[s]    <= n_q[s];
                r_rem[s]  <= n_rem[s];
                r_side[s] <= w_in_side;
            end
        end
    end

    assign o_valid     = r_vld[STAGES-1];
    assign o_busy      = |r_vld;
    assign o_quotient  = r_q[STAGES-1];
    assign o_remainder = r_rem[STAGES-1];
    assign o_side      = r_side[STAGES-1];

endmodule

### rtl/fat_volume_geometry_calc_unit.sv
// FAT volume geometry unit: takes one cluster number per cycle while the input is
// not stalled and reports the volume kind, region starts, the cluster's first
// sector and its table entry location. After reset and after every configuration
// write a setup sequencer recomputes the volume geometry with a shared bit-serial
// divider, holding the input stalled through two divisions (each a start step, the
// bit steps and a done step) and two add steps; configuration writes are taken
// only while that sequencer is done and no lookup is in flight, and the input is
// stalled in the cycle of a write. Each lookup then passes an input stage (cluster
// offset multiply), eight divider stages (four bits of byte-offset / sector-size
// each) and an output register; the input stage loads on the accepting edge, and
// one lookup per cycle is sustained while the output is not stalled. The whole
// pipeline advances when the output register is empty or taken, so a stall at the
// output holds every stage.
// Depends on fvg_pkg, fvg_div_iter and fvg_div_pipe.
module fat_volume_geometry_calc_unit
    import fvg_pkg::*;
#(
    parameter int P_DIV_BITS = FVG_DIV_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [FVG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]              i_cfg_data,
    // lookup input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [FVG_CLUSTER_W-1:0] i_in_cluster_number,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_out_volume_kind,
    output logic [31:0]              o_out_cluster_count,
    output logic [12:0]              o_out_root_sectors,
    output logic [FVG_ROOT_W-1:0]    o_out_root_dir_start,
    output logic [FVG_DATA_W-1:0]    o_out_data_region_start,
    output logic [31:0]              o_out_cluster_start_sector,
    output logic [31:0]              o_out_entry_sector,
    output logic [FVG_OFF_W-1:0]     o_out_entry_byte_offset,
    output logic [1:0]               o_out_status
);

    // Configuration registers.
    logic [FVG_BPS_W-1:0] r_bps;
    logic [FVG_SPC_W-1:0] r_spc;
    logic [15:0]          r_res;
    logic [7:0]           r_copies;
    logic [15:0]          r_root_n;
    logic [15:0]          r_tsize;
    logic [15:0]          r_tot16;
    logic [31:0]          r_tot32;

    // Derived geometry.
    logic [FVG_RDS_EXACT_W-1:0] r_rds;
    logic [FVG_ROOT_W-1:0]      r_root;
    logic [FVG_DATA_W-1:0]      r_data;
    logic [31:0]                r_count;
    logic [1:0]                 r_kind;

    t_geo_state r_state;
    t_geo_state n_state;
    t_div_req   w_req;
    logic       w_div_done;
    logic [31:0] w_div_q;
    logic       w_geo_ready;

    logic [FVG_BPS_W-1:0] w_bps_eff;
    logic [FVG_SPC_W-1:0] w_spc_eff;
    logic [31:0]          w_rds_num;
    logic [31:0]          w_total;
    logic [31:0]          w_data_secs;
    logic [FVG_ROOT_W-1:0] w_copy_prod;

    logic w_cfg_wr;
    logic w_adv;
    logic w_in_acc;
    logic w_pipe_busy;

    // Zero sizes count as one.
    assign w_bps_eff = (r_bps == '0) ? FVG_BPS_W'(1) : r_bps;
    assign w_spc_eff = (r_spc == '0) ? FVG_SPC_W'(1) : r_spc;

    assign w_cfg_wr = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps    <= FVG_BPS_W'(512);
            r_spc    <= FVG_SPC_W'(1);
            r_res    <= 16'd1;
            r_copies <= 8'd2;
            r_root_n <= 16'd512;
            r_tsize  <= 16'd0;
            r_tot16  <= 16'd0;
            r_tot32  <= 32'd0;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                REG_BPS:   r_bps    <= i_cfg_data[FVG_BPS_W-1:0];
                REG_SPC:   r_spc    <= i_cfg_data[FVG_SPC_W-1:0];
                REG_RES:   r_res    <= i_cfg_data[15:0];
                REG_COPY:  r_copies <= i_cfg_data[7:0];
                REG_ROOTN: r_root_n <= i_cfg_data[15:0];
                REG_TSIZE: r_tsize  <= i_cfg_data[15:0];
                REG_TOT16: r_tot16  <= i_cfg_data[15:0];
                REG_TOT32: r_tot32  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- geometry setup sequencer ----------------
    assign w_rds_num   = {11'd0, r_root_n, 5'd0} + {19'd0, w_bps_eff - FVG_BPS_W'(1)};
    assign w_copy_prod = {16'd0, r_copies} * {8'd0, r_tsize};
    assign w_total     = (r_tot16 != 16'd0) ? {16'd0, r_tot16} : r_tot32;
    assign w_data_secs = (w_total > {7'd0, r_data}) ? (w_total - {7'd0, r_data}) : 32'd0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            GEO_RDS_GO:   n_state = GEO_RDS_WAIT;
            GEO_RDS_WAIT: if (w_div_done) n_state = GEO_ROOT;
            GEO_ROOT:     n_state = GEO_DATA;
            GEO_DATA:     n_state = GEO_CNT_GO;
            GEO_CNT_GO:   n_state = GEO_CNT_WAIT;
            GEO_CNT_WAIT: if (w_div_done) n_state = GEO_READY;
            GEO_READY:    if (w_cfg_wr) n_state = GEO_RDS_GO;
            default:      n_state = GEO_RDS_GO;
        endcase
    end

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = w_data_secs;
        w_req.divisor  = {5'd0, w_spc_eff};
        w_geo_ready    = 1'b0;
        case (r_state)
            GEO_RDS_GO: begin
                w_req.start    = 1'b1;
                w_req.dividend = w_rds_num;
                w_req.divisor  = w_bps_eff;
            end
            GEO_CNT_GO: w_req.start = 1'b1;
            GEO_READY:  w_geo_ready = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GEO_RDS_GO;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch each geometry value as its step completes.
    always_ff @(posedge i_clk) begin
        if (r_state == GEO_RDS_WAIT && w_div_done) begin
            r_rds <= w_div_q[FVG_RDS_EXACT_W-1:0];
        end
        if (r_state == GEO_ROOT) begin
            r_root <= {8'd0, r_res} + w_copy_prod;
        end
        if (r_state == GEO_DATA) begin
            r_data <= {1'b0, r_root} + {3'd0, r_rds};
        end
        if (r_state == GEO_CNT_WAIT && w_div_done) begin
            r_count <= w_div_q;
            if (w_div_q < FVG_FAT12_LIMIT) begin
                r_kind <= KIND_FAT12;
            end else if (w_div_q < FVG_FAT16_LIMIT) begin
                r_kind <= KIND_FAT16;
            end else begin
                r_kind <= KIND_FAT32;
            end
        end
    end

    fvg_div_iter u_div_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // ---------------- lookup pipeline ----------------
    logic        r_s0_valid;
    logic        r_s0_low;
    logic [31:0] r_s0_prod;
    logic [31:0] r_s0_foff;
    logic [FVG_CLUSTER_W-1:0]            w_cm2;
    logic [FVG_CLUSTER_W+FVG_SPC_W-1:0] w_prod;
    t_side       w_side_in;
    t_side       w_side_out;
    logic        w_pv;
    logic [31:0] w_pq;
    logic [FVG_BPS_W-1:0] w_prem;
    logic        w_pbusy;

    // Advance everything when the output register is free or being taken.
    // Hold the input off in the cycle of a configuration write.
    assign w_adv       = !o_out_valid || !i_out_stall;
    assign o_in_stall  = !w_adv || !w_geo_ready || w_cfg_wr;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_pipe_busy = r_s0_valid || w_pbusy || o_out_valid;
    assign o_cfg_ready = w_geo_ready && !w_pipe_busy;

    assign w_cm2  = i_in_cluster_number - FVG_CLUSTER_W'(2);
    assign w_prod = {{FVG_SPC_W{1'b0}}, w_cm2} * {{FVG_CLUSTER_W{1'b0}}, w_spc_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_in_acc) begin
            r_s0_low  <= (i_in_cluster_number < FVG_CLUSTER_W'(2));
            r_s0_prod <= w_prod[31:0];
            // FAT16 entries are two bytes, FAT32 four.
            r_s0_foff <= (r_kind == KIND_FAT16) ? {3'd0, i_in_cluster_number, 1'b0}
                                                : {2'd0, i_in_cluster_number, 2'd0};
        end
    end

    assign w_side_in.low_cluster  = r_s0_low;
    assign w_side_in.start_sector = r_s0_low ? 32'd0 : (r_s0_prod + {7'd0, r_data});

    fvg_div_pipe #(
        .P_BITS (P_DIV_BITS)
    ) u_div_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_valid     (r_s0_valid),
        .i_dividend  (r_s0_foff),
        .i_divisor   (w_bps_eff),
        .i_side      (w_side_in),
        .o_valid     (w_pv),
        .o_busy      (w_pbusy),
        .o_quotient  (w_pq),
        .o_remainder (w_prem),
        .o_side      (w_side_out)
    );

    // Output register.
    logic                    r_out_valid;
    logic [31:0]             r_out_start;
    logic [31:0]             r_out_esec;
    logic [FVG_OFF_W-1:0]    r_out_eoff;
    logic [1:0]              r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_pv) begin
            r_out_start <= w_side_out.start_sector;
            if (r_kind == KIND_FAT12) begin
                r_out_esec <= 32'd0;
                r_out_eoff <= '0;
            end else begin
                r_out_esec <= {16'd0, r_res} + w_pq;
                r_out_eoff <= (w_prem > FVG_OFF_SAT) ? FVG_OFF_SAT[FVG_OFF_W-1:0]
                                                     : w_prem[FVG_OFF_W-1:0];
            end
            if (w_side_out.low_cluster) begin
                r_out_status <= STATUS_LOW_CLUSTER;
            end else if (r_kind == KIND_FAT12) begin
                r_out_status <= STATUS_FAT12_UNSUP;
            end else begin
                r_out_status <= STATUS_OK;
            end
        end
    end

    // Geometry fields hold still while any lookup is in flight.
    assign o_out_valid                = r_out_valid;
    assign o_out_volume_kind          = r_kind;
    assign o_out_cluster_count        = r_count;
    assign o_out_root_sectors         = (r_rds > {9'd0, FVG_RDS_SAT}) ? FVG_RDS_SAT
                                                                      : r_rds[12:0];
    assign o_out_root_dir_start       = r_root;
    assign o_out_data_region_start    = r_data;
    assign o_out_cluster_start_sector = r_out_start;
    assign o_out_entry_sector         = r_out_esec;
    assign o_out_entry_byte_offset    = r_out_eoff;
    assign o_out_status               = r_out_status;

endmodule

### rtl/fvg_checker.sv
// Port-level checker for the FAT volume geometry unit, bound to the top level.
// Depends on fvg_pkg and fat_volume_geometry_calc_unit_assert.svh.
`include "fat_volume_geometry_calc_unit_assert.svh"

module fvg_checker
    import fvg_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_out_volume_kind,
    input logic [31:0] o_out_cluster_start_sector,
    input logic [1:0]  o_out_status
);

    `FVG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `FVG_ASSERT_NEXT(a_cfg_recalc, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, o_in_stall, "lookup taken during geometry recompute")
    `FVG_ASSERT_IMPLY(a_low_zero, i_clk, i_rst_n, o_out_valid && o_out_status == STATUS_LOW_CLUSTER, o_out_cluster_start_sector == 32'd0, "low cluster start not zero")
    `FVG_ASSERT_IMPLY(a_unsup_kind, i_clk, i_rst_n, o_out_valid && o_out_status == STATUS_FAT12_UNSUP, o_out_volume_kind == KIND_FAT12, "unsupported status on non-FAT12 volume")

endmodule

bind fat_volume_geometry_calc_unit fvg_checker u_fvg_checker (
    .i_clk                      (i_clk),
    .i_rst_n                    (i_rst_n),
    .i_cfg_valid                (i_cfg_valid),
    .o_cfg_ready                (o_cfg_ready),
    .o_in_stall                 (o_in_stall),
    .o_out_valid                (o_out_valid),
    .i_out_stall                (i_out_stall),
    .o_out_volume_kind          (o_out_volume_kind),
    .o_out_cluster_start_sector (o_out_cluster_start_sector),
    .o_out_status               (o_out_status)
);

### test/testbench.sv
// Self-checking testbench of fat_volume_geometry_calc_unit: geometry registers and
// cluster lookups, with an in-bench geometry predictor and an in-order result check.
// Depends on fvg_pkg and the RTL of the unit.
module testbench;
    import fvg_pkg::*;

    // One expected lookup result, at the widths of the result ports
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] count;
        logic [12:0] rds;
        logic [23:0] root_start;
        logic [24:0] data_start;
        logic [31:0] clus_sector;
        logic [31:0] ent_sector;
        logic [11:0] ent_offset;
        logic [1:0]  status;
    } t_geometry;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [27:0] i_in_cluster_number;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_out_volume_kind;
    logic [31:0] o_out_cluster_count;
    logic [12:0] o_out_root_sectors;
    logic [23:0] o_out_root_dir_start;
    logic [24:0] o_out_data_region_start;
    logic [31:0] o_out_cluster_start_sector;
    logic [31:0] o_out_entry_sector;
    logic [11:0] o_out_entry_byte_offset;
    logic [1:0]  o_out_status;

    // Shadow copy of the geometry registers, indexed by register code
    logic [31:0] geo_regs [8];
    t_geometry   pending_results [$];
    int          mismatch_count;
    int          lookups_sent;
    int          results_seen;
    int          cfg_writes;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          quiet_cycles;
    int          kind_seen [3];

    fat_volume_geometry_calc_unit uut (
        .i_clk                      (i_clk),
        .i_rst_n                    (i_rst_n),
        .i_cfg_valid                (i_cfg_valid),
        .o_cfg_ready                (o_cfg_ready),
        .i_cfg_index                (i_cfg_index),
        .i_cfg_data                 (i_cfg_data),
        .i_in_valid                 (i_in_valid),
        .o_in_stall                 (o_in_stall),
        .i_in_cluster_number        (i_in_cluster_number),
        .o_out_valid                (o_out_valid),
        .i_out_stall                (i_out_stall),
        .o_out_volume_kind          (o_out_volume_kind),
        .o_out_cluster_count        (o_out_cluster_count),
        .o_out_root_sectors         (o_out_root_sectors),
        .o_out_root_dir_start       (o_out_root_dir_start),
        .o_out_data_region_start    (o_out_data_region_start),
        .o_out_cluster_start_sector (o_out_cluster_start_sector),
        .o_out_entry_sector         (o_out_entry_sector),
        .o_out_entry_byte_offset    (o_out_entry_byte_offset),
        .o_out_status               (o_out_status)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Compute the expected result of one lookup from the shadow registers.
    // All sums wrap at 32 bits, as the block's address arithmetic does.
    function automatic t_geometry predict_geometry(logic [27:0] cluster);
        t_geometry   g;
        logic [31:0] bps;
        logic [31:0] spc;
        logic [31:0] rds_exact;
        logic [31:0] root;
        logic [31:0] data;
        logic [31:0] total;
        logic [31:0] data_secs;
        logic [31:0] count;
        logic [31:0] fat_off;
        logic [31:0] off;
        logic        low;
        bps = (geo_regs[REG_BPS] == 0) ? 32'd1 : geo_regs[REG_BPS];
        spc = (geo_regs[REG_SPC] == 0) ? 32'd1 : geo_regs[REG_SPC];
        rds_exact = (geo_regs[REG_ROOTN] * 32'd32 + bps - 32'd1) / bps;
        root = geo_regs[REG_RES] + geo_regs[REG_COPY] * geo_regs[REG_TSIZE];
        data = root + rds_exact;
        total = (geo_regs[REG_TOT16] != 0) ? geo_regs[REG_TOT16] : geo_regs[REG_TOT32];
        data_secs = (total > data) ? total - data : 32'd0;
        count = data_secs / spc;
        if (count < FVG_FAT12_LIMIT)
            g.kind = KIND_FAT12;
        else if (count < FVG_FAT16_LIMIT)
            g.kind = KIND_FAT16;
        else
            g.kind = KIND_FAT32;
        low = (cluster < 28'd2);
        g.count = count;
        g.rds = (rds_exact > 32'd8191) ? FVG_RDS_SAT : rds_exact[12:0];
        g.root_start = root[23:0];
        g.data_start = data[24:0];
        g.clus_sector = low ? 32'd0 : (32'(cluster) - 32'd2) * spc + data;
        g.ent_sector = 32'd0;
        g.ent_offset = 12'd0;
        if (g.kind != KIND_FAT12) begin
            fat_off = (g.kind == KIND_FAT16) ? 32'(cluster) * 32'd2 : 32'(cluster) * 32'd4;
            g.ent_sector = geo_regs[REG_RES] + fat_off / bps;
            off = fat_off % bps;
            g.ent_offset = (off > 32'd4095) ? 12'd4095 : off[11:0];
        end
        if (low)
            g.status = STATUS_LOW_CLUSTER;
        else if (g.kind == KIND_FAT12)
            g.status = STATUS_FAT12_UNSUP;
        else
            g.status = STATUS_OK;
        return g;
    endfunction

    // Drive the result stall at the falling edge according to the current pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Check every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_geometry e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no lookup outstanding");
                mismatch_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_out_volume_kind !== e.kind) begin
                    $error("volume_kind: expected %0d, got %0d", e.kind, o_out_volume_kind);
                    mismatch_count++;
                end
                if (o_out_cluster_count !== e.count) begin
                    $error("cluster_count: expected %0d, got %0d", e.count,
                           o_out_cluster_count);
                    mismatch_count++;
                end
                if (o_out_root_sectors !== e.rds) begin
                    $error("root_sectors: expected %0d, got %0d", e.rds,
                           o_out_root_sectors);
                    mismatch_count++;
                end
                if (o_out_root_dir_start !== e.root_start) begin
                    $error("root_dir_start: expected %0d, got %0d", e.root_start,
                           o_out_root_dir_start);
                    mismatch_count++;
                end
                if (o_out_data_region_start !== e.data_start) begin
                    $error("data_region_start: expected %0d, got %0d", e.data_start,
                           o_out_data_region_start);
                    mismatch_count++;
                end
                if (o_out_cluster_start_sector !== e.clus_sector) begin
                    $error("cluster_start_sector: expected %0d, got %0d", e.clus_sector,
                           o_out_cluster_start_sector);
                    mismatch_count++;
                end
                if (o_out_entry_sector !== e.ent_sector) begin
                    $error("entry_sector: expected %0d, got %0d", e.ent_sector,
                           o_out_entry_sector);
                    mismatch_count++;
                end
                if (o_out_entry_byte_offset !== e.ent_offset) begin
                    $error("entry_byte_offset: expected %0d, got %0d", e.ent_offset,
                           o_out_entry_byte_offset);
                    mismatch_count++;
                end
                if (o_out_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_out_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run once no transaction has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Write one geometry register; the block only grants this when it is idle.
    // Valid stays high into the next write; the caller drops it after the last one.
    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (index)
            REG_BPS:   geo_regs[index] = value & 32'h1FFF;
            REG_SPC,
            REG_COPY:  geo_regs[index] = value & 32'hFF;
            REG_TOT32: geo_regs[index] = value;
            default:   geo_regs[index] = value & 32'hFFFF;
        endcase
        cfg_writes++;
        @(negedge i_clk);
    endtask

    // Drop the lookup valid, let every result drain and the pipeline settle
    task automatic drain_lookups();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Load a whole geometry set while the block is idle
    task automatic load_geometry(logic [31:0] bps, logic [31:0] spc, logic [31:0] res,
                                 logic [31:0] copies, logic [31:0] rootn,
                                 logic [31:0] tsize, logic [31:0] tot16,
                                 logic [31:0] tot32);
        drain_lookups();
        write_reg(REG_BPS, bps);
        write_reg(REG_SPC, spc);
        write_reg(REG_RES, res);
        write_reg(REG_COPY, copies);
        write_reg(REG_ROOTN, rootn);
        write_reg(REG_TSIZE, tsize);
        write_reg(REG_TOT16, tot16);
        write_reg(REG_TOT32, tot32);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one cluster lookup; valid stays high into the next call unless idling
    task automatic send_cluster(logic [27:0] cluster);
        t_geometry g;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_cluster_number <= cluster;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        g = predict_geometry(cluster);
        pending_results.push_back(g);
        kind_seen[g.kind]++;
        lookups_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_edge_clusters();
        send_cluster(28'd0);
        send_cluster(28'd1);
        send_cluster(28'd2);
        send_cluster(28'hFFFFFFF);
    endtask

    // Reset values: no total sectors, so a FAT12 volume with no data clusters
    task automatic test_reset_geometry();
        send_edge_clusters();
    endtask

    task automatic test_fat16_volume();
        load_geometry(512, 4, 4, 2, 512, 64, 60000, 32'hDEADBEEF);
        send_edge_clusters();
    endtask

    // Short total of zero selects the long total
    task automatic test_fat32_volume();
        load_geometry(4096, 128, 32, 2, 0, 8000, 0, 32'hFFFFFFFF);
        send_edge_clusters();
    endtask

    // Zero divisors are taken as one; the root directory sector count saturates its port
    task automatic test_zero_divisors();
        load_geometry(0, 0, 65535, 255, 65535, 65535, 0, 32'hFFFFFFFF);
        send_edge_clusters();
    endtask

    // Sector size above 4096 makes the entry offset saturate
    task automatic test_large_sector();
        load_geometry(8191, 255, 0, 0, 65535, 0, 0, 32'h7FFFFFFF);
        send_cluster(28'd4000);
        send_cluster(28'd2047);
        send_cluster(28'h5555555);
        send_cluster(28'hAAAAAAA);
    endtask

    function automatic logic [27:0] pick_cluster();
        case ($urandom_range(3))
            0:       return 28'($urandom_range(3));
            1:       return 28'hFFFFFFF - 28'($urandom_range(3));
            2:       return 28'($urandom_range(70000));
            default: return 28'($urandom);
        endcase
    endfunction

    // Random geometry, biased toward layouts that reach each volume kind
    task automatic load_random_geometry();
        logic [31:0] bps;
        logic [31:0] tot16;
        logic [31:0] tot32;
        case ($urandom_range(4))
            0:       bps = 512;
            1:       bps = 1024;
            2:       bps = 4096;
            default: bps = $urandom;
        endcase
        tot16 = ($urandom_range(1) != 0) ? $urandom : 32'd0;
        tot32 = $urandom;
        if ($urandom_range(1) != 0)
            load_geometry(bps, $urandom_range(8), $urandom_range(64), $urandom_range(3),
                          $urandom_range(1024), $urandom_range(512), tot16, tot32);
        else
            load_geometry(bps, $urandom, $urandom, $urandom, $urandom, $urandom,
                          tot16, tot32);
    endtask

    task automatic test_random_lookups(int idle_pct, int stall_pct);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < 4; n++) begin
            load_random_geometry();
            repeat (25) send_cluster(pick_cluster());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_BPS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_cluster_number = '0;
        i_out_stall = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        mismatch_count = 0;
        lookups_sent = 0;
        results_seen = 0;
        cfg_writes = 0;
        quiet_cycles = 0;
        kind_seen = '{0, 0, 0};
        geo_regs = '{512, 1, 1, 2, 512, 0, 0, 0};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_fat16_volume();
        test_fat32_volume();
        test_zero_divisors();
        test_large_sector();
        test_random_lookups(0, 0);
        test_random_lookups(66, 0);
        test_random_lookups(0, 66);
        test_random_lookups(24, 24);
        drain_lookups();

        $display("%0d lookups, %0d results, %0d register writes", lookups_sent,
                 results_seen, cfg_writes);
        $display("volume kinds hit: FAT12 %0d, FAT16 %0d, FAT32 %0d", kind_seen[0],
                 kind_seen[1], kind_seen[2]);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
